/* hw/rtl/pfb_pkg.sv */
`default_nettype none

package pfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int ROWS_DEF    = 64;

  localparam logic [2:0] MODE_CURSOR = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_FILL   = 3'd2;
  localparam logic [2:0] MODE_BITMAP = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] INK_NORMAL = 2'd0;
  localparam logic [1:0] INK_INVERT = 2'd1;
  localparam logic [1:0] INK_XOR    = 2'd2;

  localparam logic [7:0] BYTE_CLEAR = 8'h00;
  localparam logic [7:0] BYTE_FILL  = 8'hFF;

  // Merge a shifted bitmap byte into the upper or the lower of two store bytes.
  function automatic logic [7:0] merge_byte(input logic [7:0] old_v,
                                            input logic [7:0] pat,
                                            input logic [2:0] sh,
                                            input logic       lower,
                                            input logic       ink_xor,
                                            input logic       keep);
    logic [15:0] wide;
    logic [7:0]  hi_mask;
    logic [7:0]  part;
    logic [7:0]  clr_mask;
    logic [7:0]  res;
    wide     = {8'h00, pat} << sh;
    hi_mask  = 8'hFF << sh;
    part     = lower ? wide[15:8] : wide[7:0];
    clr_mask = lower ? hi_mask : ~hi_mask;
    if (ink_xor) begin
      res = old_v ^ part;
    end else begin
      res = (keep ? old_v : (old_v & clr_mask)) | part;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/page_framebuffer_bitmap_blit.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    mode_i .. read_column_i
// out       output     out_valid_o / out_ready_i  read_data_o .. draw_done_o
//
// A new transaction is taken only in idle, after the last one is done. Set cursor, unused
// modes, a read outside the store and a bitmap byte that draws nothing go straight to the
// result; a store read makes one read of the store; a drawn bitmap byte makes one or two
// read-modify-write passes; clear and fill write every store byte in turn through the
// single store write port. After reset a clearing pass over the whole store runs first.
// A waiting result holds the next transaction in its final state (S_DONE) only.
`default_nettype none

module page_framebuffer_bitmap_blit #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
  parameter int ROWS    = pfb_pkg::ROWS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] pos_x_i,
  input  wire logic [7:0] pos_y_i,
  input  wire logic [7:0] bitmap_length_i,
  input  wire logic [7:0] bitmap_height_i,
  input  wire logic [1:0] ink_mode_i,
  input  wire logic       see_through_i,
  input  wire logic [7:0] bitmap_byte_i,
  input  wire logic       first_of_bitmap_i,
  input  wire logic [2:0] read_page_i,
  input  wire logic [6:0] read_column_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] read_data_o,
  output      logic [7:0] cursor_col_o,
  output      logic [7:0] cursor_row_o,
  output      logic       draw_done_o
);

  localparam int NUM_PAGES  = (ROWS + 7) / 8;
  localparam int STORE_SIZE = NUM_PAGES * COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int WIDE_W     = $clog2(64 * COLUMNS + 512);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_LO    = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_INIT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [7:0] store_mem [STORE_SIZE];
  logic [7:0] rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [ADDR_W-1:0] mem_ra;
  logic [7:0]        mem_wd;

  logic [2:0] state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [7:0] cur_col_q, cur_col_d;
  logic [7:0] cur_row_q, cur_row_d;
  logic [7:0] blit_col_q, blit_col_d;
  logic [5:0] blit_page_q, blit_page_d;
  logic [7:0] clip_len_q, clip_len_d;
  logic [5:0] clip_pages_q, clip_pages_d;
  logic [2:0] style_q, style_d;
  logic       abort_q, abort_d;
  logic [7:0] lat_len_q, lat_len_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] sweep_val_q, sweep_val_d;
  logic [7:0] res_read_q, res_read_d;
  logic       res_done_q, res_done_d;
  logic       load_out;

  logic [2:0] mode_q;
  logic [7:0] pos_x_q, pos_y_q, len_q, hgt_q, byte_q;
  logic [1:0] ink_q;
  logic       see_q, first_q;
  logic [2:0] rpage_q;
  logic [6:0] rcol_q;

  logic [ADDR_W-1:0] up_addr_q, lo_addr_q;
  logic [2:0]        shift_q;
  logic              dr_lo_q;
  logic [7:0]        pat_q;

  logic [7:0] read_data_q, cursor_col_q, cursor_row_q;
  logic       draw_done_q;

  logic in_fire;

  logic [8:0]        sum_x, sum_y;
  logic [7:0]        clip_l, clip_h;
  logic              rej;
  logic [5:0]        new_pages;
  logic [7:0]        eff_col, eff_len, eff_lat;
  logic [5:0]        eff_page, eff_pages;
  logic [1:0]        eff_ink;
  logic              go;
  logic [8:0]        pix_x, pix_y;
  logic [WIDE_W-1:0] up_idx, lo_idx;
  logic              up_ok, lo_ok;
  logic [7:0]        col_inc;
  logic [5:0]        page_inc;
  logic              wrap, fin;
  logic              rd_ok;
  logic [WIDE_W-1:0] rd_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign cursor_col_o = cursor_col_q;
  assign cursor_row_o = cursor_row_q;
  assign draw_done_o  = draw_done_q;

  always_comb begin
    sum_x  = {1'b0, len_q} + {1'b0, cur_col_q};
    sum_y  = {1'b0, hgt_q} + {1'b0, cur_row_q};
    clip_l = (sum_x > 9'(COLUMNS - 1)) ? 8'(9'(COLUMNS - 1) - {1'b0, cur_col_q}) : len_q;
    clip_h = (sum_y > 9'(ROWS - 1)) ? 8'(9'(ROWS - 1) - {1'b0, cur_row_q}) : hgt_q;
    rej    = (clip_l == 8'd0) || ({1'b0, clip_l} > 9'(COLUMNS - 1)) ||
             (clip_h == 8'd0) || ({1'b0, clip_h} > 9'(ROWS - 1));
    new_pages = 6'(({1'b0, clip_h} + 9'd7) >> 3);

    eff_col   = first_q ? 8'd0 : blit_col_q;
    eff_page  = first_q ? 6'd0 : blit_page_q;
    eff_len   = first_q ? clip_l : clip_len_q;
    eff_pages = first_q ? new_pages : clip_pages_q;
    eff_lat   = first_q ? len_q : lat_len_q;
    eff_ink   = first_q ? ink_q : style_q[1:0];
    go        = first_q ? !rej : (!abort_q && (blit_page_q < clip_pages_q));

    pix_x  = {1'b0, cur_col_q} + {1'b0, eff_col};
    pix_y  = {1'b0, cur_row_q} + {eff_page, 3'b000};
    up_idx = WIDE_W'(pix_y[8:3]) * WIDE_W'(COLUMNS) + WIDE_W'(pix_x);
    lo_idx = up_idx + WIDE_W'(COLUMNS);
    up_ok  = up_idx < WIDE_W'(STORE_SIZE);
    lo_ok  = (pix_y[2:0] != 3'd0) && (({1'b0, pix_y} + 10'd8) <= 10'(ROWS - 1)) &&
             (lo_idx < WIDE_W'(STORE_SIZE));

    col_inc  = eff_col + 8'd1;
    page_inc = eff_page + 6'd1;
    wrap     = col_inc >= eff_lat;
    fin      = wrap && (page_inc >= eff_pages);

    rd_ok  = (6'(rpage_q) < 6'(NUM_PAGES)) && (9'(rcol_q) < 9'(COLUMNS));
    rd_idx = WIDE_W'(rpage_q) * WIDE_W'(COLUMNS) + WIDE_W'(rcol_q);
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    blit_col_d   = blit_col_q;
    blit_page_d  = blit_page_q;
    clip_len_d   = clip_len_q;
    clip_pages_d = clip_pages_q;
    style_d      = style_q;
    abort_d      = abort_q;
    lat_len_d    = lat_len_q;
    sweep_val_d  = sweep_val_q;
    res_read_d   = res_read_q;
    res_done_d   = res_done_q;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = cnt_q;
    mem_wd       = sweep_val_q;
    mem_re       = 1'b0;
    mem_ra       = up_idx[ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_read_d = 8'd0;
        res_done_d = 1'b0;
        state_d    = S_DONE;
        case (mode_q)
          pfb_pkg::MODE_CURSOR: begin
            cur_col_d    = pos_x_q;
            cur_row_d    = pos_y_q;
            clip_pages_d = 6'd0;
            blit_page_d  = 6'd0;
            blit_col_d   = 8'd0;
          end
          pfb_pkg::MODE_CLEAR: begin
            sweep_val_d = pfb_pkg::BYTE_CLEAR;
            cnt_d       = '0;
            state_d     = S_SWEEP;
          end
          pfb_pkg::MODE_FILL: begin
            sweep_val_d = pfb_pkg::BYTE_FILL;
            cnt_d       = '0;
            state_d     = S_SWEEP;
          end
          pfb_pkg::MODE_BITMAP: begin
            if (first_q) begin
              lat_len_d   = len_q;
              style_d     = {see_q, ink_q};
              blit_col_d  = 8'd0;
              blit_page_d = 6'd0;
              if (rej) begin
                abort_d      = 1'b1;
                clip_len_d   = 8'd0;
                clip_pages_d = 6'd0;
                res_done_d   = 1'b1;
              end else begin
                abort_d      = 1'b0;
                clip_len_d   = clip_l;
                clip_pages_d = new_pages;
              end
            end
            if (go) begin
              if ((eff_col < eff_len) && up_ok) begin
                mem_re  = 1'b1;
                mem_ra  = up_idx[ADDR_W-1:0];
                state_d = S_UP;
              end
              blit_col_d = wrap ? 8'd0 : col_inc;
              if (wrap) begin
                blit_page_d = page_inc;
              end
              if (fin) begin
                cur_col_d  = cur_col_q + eff_len;
                res_done_d = 1'b1;
              end
            end
          end
          pfb_pkg::MODE_READ: begin
            if (rd_ok) begin
              mem_re  = 1'b1;
              mem_ra  = rd_idx[ADDR_W-1:0];
              state_d = S_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_UP: begin
        mem_we = 1'b1;
        mem_wa = up_addr_q;
        mem_wd = pfb_pkg::merge_byte(rd_data_q, pat_q, shift_q, 1'b0,
                                     style_q[1:0] == pfb_pkg::INK_XOR, style_q[2]);
        if (dr_lo_q) begin
          mem_re  = 1'b1;
          mem_ra  = lo_addr_q;
          state_d = S_LO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LO: begin
        mem_we  = 1'b1;
        mem_wa  = lo_addr_q;
        mem_wd  = pfb_pkg::merge_byte(rd_data_q, pat_q, shift_q, 1'b1,
                                      style_q[1:0] == pfb_pkg::INK_XOR, style_q[2]);
        state_d = S_DONE;
      end
      S_RD: begin
        res_read_d = rd_data_q;
        state_d    = S_DONE;
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(STORE_SIZE - 1)) begin
          state_d = S_DONE;
        end
      end
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = pfb_pkg::BYTE_CLEAR;
        cnt_d  = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(STORE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      cur_col_q    <= 8'd0;
      cur_row_q    <= 8'd0;
      blit_col_q   <= 8'd0;
      blit_page_q  <= 6'd0;
      clip_len_q   <= 8'd0;
      clip_pages_q <= 6'd0;
      style_q      <= 3'd0;
      abort_q      <= 1'b0;
      lat_len_q    <= 8'd0;
      out_valid_q  <= 1'b0;
      sweep_val_q  <= pfb_pkg::BYTE_CLEAR;
      res_read_q   <= 8'd0;
      res_done_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      blit_col_q   <= blit_col_d;
      blit_page_q  <= blit_page_d;
      clip_len_q   <= clip_len_d;
      clip_pages_q <= clip_pages_d;
      style_q      <= style_d;
      abort_q      <= abort_d;
      lat_len_q    <= lat_len_d;
      out_valid_q  <= out_valid_d;
      sweep_val_q  <= sweep_val_d;
      res_read_q   <= res_read_d;
      res_done_q   <= res_done_d;
    end
  end

  // Hold the transaction while it is worked on.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_i;
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      len_q   <= bitmap_length_i;
      hgt_q   <= bitmap_height_i;
      ink_q   <= ink_mode_i;
      see_q   <= see_through_i;
      byte_q  <= bitmap_byte_i;
      first_q <= first_of_bitmap_i;
      rpage_q <= read_page_i;
      rcol_q  <= read_column_i;
    end
    if (state_q == S_EXEC) begin
      up_addr_q <= up_idx[ADDR_W-1:0];
      lo_addr_q <= lo_idx[ADDR_W-1:0];
      shift_q   <= pix_y[2:0];
      dr_lo_q   <= lo_ok;
      pat_q     <= byte_q ^ ((eff_ink == pfb_pkg::INK_INVERT) ? 8'hFF : 8'h00);
    end
    if (load_out) begin
      read_data_q  <= res_read_q;
      cursor_col_q <= cur_col_q;
      cursor_row_q <= cur_row_q;
      draw_done_q  <= res_done_q;
    end
  end

endmodule

`default_nettype wire
